// File: hdl/srsw_pkg.sv
package srsw_pkg;

   localparam int SEQ_SPACE = 8;
   localparam int SEQ_W = 3;
   localparam logic [SEQ_W-1:0] WINDOW_RESET = 3'd4;
   localparam logic [SEQ_W-1:0] WINDOW_MAX = SEQ_W'(SEQ_SPACE - 1);

   typedef enum logic [1:0] {
      REQ_SEND    = 2'd0,
      REQ_ACK     = 2'd1,
      REQ_TIMEOUT = 2'd2,
      REQ_NONE    = 2'd3
   } req_code_type;

   // Decision for one item, taken in the accept cycle
   typedef struct packed {
      logic             accepted;
      logic             tx_valid;
      logic             tx_from_mem;
      logic [SEQ_W-1:0] tx_seq;
      logic             timer_start;
      logic             timer_stop;
      logic [SEQ_W-1:0] timer_seq;
   } dec_type;

endpackage

// File: hdl/srsw_ram.sv
module srsw_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/srsw_ctrl.sv
module srsw_ctrl
   import srsw_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_fire,
   input  logic [1:0]       req_type,
   input  logic [SEQ_W-1:0] req_seq_num,
   input  logic             req_checksum_ok,
   input  logic             csr_fire,
   input  logic [SEQ_W-1:0] csr_data,
   output dec_type          dec,
   output logic [SEQ_W-1:0] base_ptr,
   output logic [SEQ_W-1:0] next_ptr
);

   logic [SEQ_W-1:0]     base_ff, base_in;
   logic [SEQ_W-1:0]     next_ff, next_in;
   logic [SEQ_W-1:0]     window_ff;
   logic [SEQ_SPACE-1:0] marks_ff, marks_in;

   logic [SEQ_W-1:0]     outstanding;
   logic [SEQ_W-1:0]     eff_window;
   logic                 seq_in_window;
   logic                 send_ok, ack_ok, timeout_ok;
   logic [SEQ_SPACE-1:0] seq_onehot, next_onehot;
   logic [SEQ_SPACE-1:0] marks_set;
   logic [SEQ_SPACE-1:0] clr_mask;
   logic [SEQ_W-1:0]     slide_cnt;

   assign outstanding   = next_ff - base_ff;
   assign eff_window    = (window_ff > WINDOW_MAX) ? WINDOW_MAX : window_ff;
   assign seq_in_window = (req_seq_num - base_ff) < outstanding;

   assign seq_onehot  = {{(SEQ_SPACE-1){1'b0}}, 1'b1} << req_seq_num;
   assign next_onehot = {{(SEQ_SPACE-1){1'b0}}, 1'b1} << next_ff;

   always_comb begin
      send_ok    = 1'b0;
      ack_ok     = 1'b0;
      timeout_ok = 1'b0;
      unique case (req_type)
         REQ_SEND:    send_ok = outstanding < eff_window;
         REQ_ACK:     ack_ok = req_checksum_ok && seq_in_window;
         REQ_TIMEOUT: timeout_ok = seq_in_window && !marks_ff[req_seq_num];
         default:     ;
      endcase
   end

   always_comb begin
      dec.accepted    = send_ok | ack_ok;
      dec.tx_valid    = send_ok | timeout_ok;
      dec.tx_from_mem = timeout_ok;
      dec.tx_seq      = send_ok ? next_ff : (timeout_ok ? req_seq_num : '0);
      dec.timer_start = send_ok | timeout_ok;
      dec.timer_stop  = ack_ok;
      dec.timer_seq   = send_ok ? next_ff :
                        ((ack_ok | timeout_ok) ? req_seq_num : '0);
   end

   // Slide: count marked slots in a run from the base, within the outstanding span
   assign marks_set = marks_ff | (ack_ok ? seq_onehot : '0);

   always_comb begin : slide_calc
      logic [2*SEQ_SPACE-1:0] rot_wide;
      logic [SEQ_SPACE-1:0]   rot;
      logic [SEQ_SPACE-1:0]   clr_rot;
      logic [2*SEQ_SPACE-1:0] clr_wide;
      logic                   run;
      rot_wide  = {marks_set, marks_set} >> base_ff;
      rot       = rot_wide[SEQ_SPACE-1:0];
      slide_cnt = '0;
      run       = 1'b1;
      for (int i = 0; i < SEQ_SPACE; i++) begin
         if (run && rot[i] && (SEQ_W'(i) < outstanding)) begin
            slide_cnt = slide_cnt + 1'b1;
         end else begin
            run = 1'b0;
         end
      end
      for (int i = 0; i < SEQ_SPACE; i++) begin
         clr_rot[i] = SEQ_W'(i) < slide_cnt;
      end
      clr_wide = {clr_rot, clr_rot} << base_ff;
      clr_mask = clr_wide[2*SEQ_SPACE-1:SEQ_SPACE];
   end

   always_comb begin
      base_in  = base_ff;
      next_in  = next_ff;
      marks_in = marks_ff;
      if (req_fire) begin
         if (send_ok) begin
            marks_in = marks_ff & ~next_onehot;
            next_in  = next_ff + 1'b1;
         end else if (ack_ok) begin
            marks_in = marks_set & ~clr_mask;
            base_in  = base_ff + slide_cnt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff   <= '0;
         next_ff   <= '0;
         marks_ff  <= '0;
         window_ff <= WINDOW_RESET;
      end else begin
         base_ff  <= base_in;
         next_ff  <= next_in;
         marks_ff <= marks_in;
         if (csr_fire) begin
            window_ff <= csr_data;
         end
      end
   end

   assign base_ptr = base_ff;
   assign next_ptr = next_ff;

   logic [SEQ_SPACE-1:0] span_rot, span_mask;
   logic [2*SEQ_SPACE-1:0] span_wide;
   always_comb begin
      for (int i = 0; i < SEQ_SPACE; i++) begin
         span_rot[i] = SEQ_W'(i) < outstanding;
      end
   end
   assign span_wide = {span_rot, span_rot} << base_ff;
   assign span_mask = span_wide[2*SEQ_SPACE-1:SEQ_SPACE];

   // marks only live on sent, unslid slots
   a_marks_in_span: assert property (@(posedge clock) disable iff (reset)
      (marks_ff & ~span_mask) == '0)
      else $error("mark set outside outstanding span");

   // after every slide the base slot is unmarked
   a_base_unmarked: assert property (@(posedge clock) disable iff (reset)
      !marks_ff[base_ff])
      else $error("base slot left marked");

   a_slide_in_span: assert property (@(posedge clock) disable iff (reset)
      slide_cnt <= outstanding)
      else $error("slide runs past the outstanding span");

endmodule

// File: hdl/selective_repeat_sender_window_core.sv
// Latency: the result of an item is strobed on rsp_* in the cycle after start is taken.
// A new item is not taken while busy is high; busy is high during the result cycle while the
//   payload RAM's registered read completes.
// The receiver cannot stall: rsp_strobe lasts one cycle and the item is then gone.
// Reset (synchronous): window base and next pointer zero, acked marks cleared,
//   window size 4; the payload RAM is not cleared, no clearing pass.
module selective_repeat_sender_window_core
   import srsw_pkg::*;
#(
   parameter int PAYLOAD_WIDTH = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [1:0]               req_type,
   input  logic [SEQ_W-1:0]         req_seq_num,
   input  logic                     req_checksum_ok,
   input  logic [PAYLOAD_WIDTH-1:0] req_message_word,
   output logic                     rsp_strobe,
   output logic                     rsp_accepted,
   output logic                     rsp_tx_valid,
   output logic [SEQ_W-1:0]         rsp_tx_seq,
   output logic [PAYLOAD_WIDTH-1:0] rsp_tx_payload,
   output logic                     rsp_timer_start,
   output logic                     rsp_timer_stop,
   output logic [SEQ_W-1:0]         rsp_timer_seq,
   output logic [SEQ_W-1:0]         rsp_window_base,
   output logic [SEQ_W-1:0]         rsp_next_seq,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [SEQ_W-1:0]         csr_data
);

   typedef enum logic [1:0] {
      PH_IDLE = 2'b01,
      PH_RESP = 2'b10
   } phase_type;

   phase_type                phase_ff, phase_in;
   dec_type                  dec;
   dec_type                  dec_ff;
   logic [PAYLOAD_WIDTH-1:0] msg_ff;
   logic [PAYLOAD_WIDTH-1:0] ram_rd_data;
   logic                     req_fire;
   logic                     csr_fire;
   logic [SEQ_W-1:0]         base_ptr, next_ptr;

   assign busy      = (phase_ff == PH_RESP);
   assign req_fire  = start & ~busy;
   assign csr_ready = ~busy;
   assign csr_fire  = csr_valid & csr_ready;

   srsw_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_fire        (req_fire),
      .req_type        (req_type),
      .req_seq_num     (req_seq_num),
      .req_checksum_ok (req_checksum_ok),
      .csr_fire        (csr_fire),
      .csr_data        (csr_data),
      .dec             (dec),
      .base_ptr        (base_ptr),
      .next_ptr        (next_ptr)
   );

   // send writes the slot at accept; timeout reads it, data lands in the result cycle
   srsw_ram #(
      .WIDTH (PAYLOAD_WIDTH),
      .DEPTH (SEQ_SPACE)
   ) u_payload_ram (
      .clock   (clock),
      .wr_en   (req_fire & dec.tx_valid & ~dec.tx_from_mem),
      .wr_addr (dec.tx_seq),
      .wr_data (req_message_word),
      .rd_addr (req_seq_num),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         PH_IDLE: if (req_fire) phase_in = PH_RESP;
         PH_RESP: phase_in = PH_IDLE;
         default: phase_in = PH_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         dec_ff <= dec;
         msg_ff <= req_message_word;
      end
   end

   assign rsp_strobe      = busy;
   assign rsp_accepted    = dec_ff.accepted;
   assign rsp_tx_valid    = dec_ff.tx_valid;
   assign rsp_tx_seq      = dec_ff.tx_seq;
   assign rsp_tx_payload  = !dec_ff.tx_valid ? '0 :
                            (dec_ff.tx_from_mem ? ram_rd_data : msg_ff);
   assign rsp_timer_start = dec_ff.timer_start;
   assign rsp_timer_stop  = dec_ff.timer_stop;
   assign rsp_timer_seq   = dec_ff.timer_seq;
   assign rsp_window_base = base_ptr;
   assign rsp_next_seq    = next_ptr;

   a_fire_then_result: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_strobe)
      else $error("accepted item produced no result");

   a_result_from_fire: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(req_fire))
      else $error("result without accepted item");

   a_timer_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !(rsp_timer_start && rsp_timer_stop))
      else $error("timer start and stop together");

   a_tx_starts_timer: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_tx_valid) |-> (rsp_timer_start && rsp_timer_seq == rsp_tx_seq))
      else $error("transmit without timer start on same slot");

endmodule
